// ----- hdl/psp_pkg.sv -----
// ----------------------------------------------------------------------------
// psp_pkg: shared types and constants of the spectrum-to-polar converter
// Request formats between the front, the pipeline and the result queue,
// queue sizes, the arctangent table and phase constants.
// ----------------------------------------------------------------------------
package psp_pkg;

  localparam int unsigned SPECTRUM_LEN_DEF = 512;

  // Queue depths are powers of two so that the pointers wrap on their own.
  localparam int unsigned ITEM_DEPTH = 4;
  localparam int unsigned ITEM_AW    = $clog2(ITEM_DEPTH);
  localparam int unsigned ITEM_CW    = $clog2(ITEM_DEPTH + 1);
  localparam int unsigned RQ_DEPTH   = 4;
  localparam int unsigned RQ_AW      = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CW      = $clog2(RQ_DEPTH + 1);

  localparam int unsigned CORDIC_STAGES = 18;
  localparam int unsigned SQRT_STEPS    = 16;

  localparam logic signed [16:0] PHASE_PI  = 17'sd32768;
  localparam logic [14:0]        HALF_PI   = 15'd16384;
  localparam logic [17:0]        Z_CLAMP   = 18'd131072;
  localparam logic [15:0]        MAG_MAX   = 16'd46341;

  // round(atan(2^-i) * 2^18 / pi)
  localparam logic [16:0] CORDIC_ATAN [CORDIC_STAGES] = '{
    17'd65536, 17'd38688, 17'd20442, 17'd10377, 17'd5208, 17'd2607,
    17'd1304,  17'd652,   17'd326,   17'd163,   17'd81,   17'd41,
    17'd20,    17'd10,    17'd5,     17'd3,     17'd1,    17'd1
  };

  typedef struct packed {
    logic [7:0]  bin;
    logic        pair;    // bin 0: packed DC and Nyquist values
    logic        re_neg;
    logic        im_neg;
    logic [15:0] ax;
    logic [15:0] ay;
  } item_t;

  typedef struct packed {
    logic [8:0]        bin;
    logic [15:0]       mag;
    logic signed [16:0] phase;
    logic              last;
  } result_t;

  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } res_wr_t;

endpackage

// ----- hdl/packed_spectrum_to_polar.sv -----
// ----------------------------------------------------------------------------
// packed_spectrum_to_polar: polar form of packed real-FFT spectrum bins
// Magnitude and phase of each bin; bin 0 splits into DC and Nyquist results.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  input    | push / full, queue style   | bin_index_i, real_part_i, imag_part_i
//  result   | pop / empty, queue style   | out_bin_o, magnitude_o, phase_o, last_o
//
//  One bin is accepted every cycle while full is low. A bin passes the input
//  queue, the 20-stage pipeline of CORDIC rotations and square-root bits and
//  the result queue, which hands out one result per pop; bin 0 gives two.
//  Reset clears only queue pointers, counts and valid bits; no clearing pass.
//  When the result queue lacks room, the whole pipeline holds and the input
//  queue fills before full rises.
// ----------------------------------------------------------------------------
module packed_spectrum_to_polar import psp_pkg::*; #(
  parameter int unsigned SPECTRUM_LEN = SPECTRUM_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         bin_index_i,
  input  logic signed [15:0] real_part_i,
  input  logic signed [15:0] imag_part_i,
  output logic               empty,
  input  logic               pop,
  output logic [8:0]         out_bin_o,
  output logic [15:0]        magnitude_o,
  output logic signed [16:0] phase_o,
  output logic               last_o
);

  item_t            item;
  logic             item_valid;
  logic             item_rd;
  logic [RQ_CW-1:0] rq_free;
  res_wr_t          wr;
  result_t          head;

  psp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .bin_index_i  (bin_index_i),
    .real_part_i  (real_part_i),
    .imag_part_i  (imag_part_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_rd_i    (item_rd)
  );

  psp_back #(
    .SPECTRUM_LEN (SPECTRUM_LEN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_rd_o    (item_rd),
    .rq_free_i    (rq_free),
    .wr_o         (wr)
  );

  psp_result_queue u_result_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .free_o (rq_free),
    .empty  (empty),
    .pop    (pop),
    .head_o (head)
  );

  assign out_bin_o   = head.bin;
  assign magnitude_o = head.mag;
  assign phase_o     = head.phase;
  assign last_o      = head.last;

endmodule

// ----- hdl/psp_front.sv -----
// ----------------------------------------------------------------------------
// psp_front: input side of the spectrum-to-polar converter
// Accepts bins, takes absolute values and signs, marks the packed DC and
// Nyquist bin, and holds the requests in a short queue for the pipeline.
// ----------------------------------------------------------------------------
module psp_front import psp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  bin_index_i,
  input  logic signed [15:0] real_part_i,
  input  logic signed [15:0] imag_part_i,
  output item_t       item_o,
  output logic        item_valid_o,
  input  logic        item_rd_i
);

  item_t              mem_q [ITEM_DEPTH];
  logic [ITEM_AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [ITEM_CW-1:0] count_q, count_d;
  item_t              item_w;
  logic               wr;

  always_comb begin
    item_w.bin    = bin_index_i;
    item_w.pair   = (bin_index_i == 8'd0);
    item_w.re_neg = real_part_i[15];
    item_w.im_neg = imag_part_i[15];
    // The most negative value maps to 32768, which still fits unsigned.
    item_w.ax     = real_part_i[15] ? 16'(-real_part_i) : 16'(real_part_i);
    item_w.ay     = imag_part_i[15] ? 16'(-imag_part_i) : 16'(imag_part_i);
  end

  assign full         = (count_q == ITEM_CW'(ITEM_DEPTH));
  assign wr           = push && !full;
  assign item_valid_o = (count_q != '0);
  assign item_o       = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q + ITEM_AW'(wr);
    rptr_d  = rptr_q + ITEM_AW'(item_rd_i);
    count_d = count_q + ITEM_CW'(wr) - ITEM_CW'(item_rd_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= item_w;
    end
  end

  a_rd_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_rd_i |-> (count_q != '0))
    else $error("request queue read while empty");

endmodule

// ----- hdl/psp_back.sv -----
// ----------------------------------------------------------------------------
// psp_back: magnitude and phase pipeline
// A vectoring CORDIC, one rotation per CORDIC stage, runs beside a restoring
// square root, one root bit per step. The whole pipeline advances together and
// holds while the result queue lacks room for the oldest stage's results.
// ----------------------------------------------------------------------------
module psp_back import psp_pkg::*; #(
  parameter int unsigned SPECTRUM_LEN = SPECTRUM_LEN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  item_t            item_i,
  input  logic             item_valid_i,
  output logic             item_rd_o,
  input  logic [RQ_CW-1:0] rq_free_i,
  output res_wr_t          wr_o
);

  localparam int unsigned SQRT_FIRST = 2;
  localparam int unsigned NST        = SQRT_FIRST + SQRT_STEPS + 2;
  localparam logic [8:0]  NYQ_BIN    = 9'((SPECTRUM_LEN / 2) % 512);

  typedef struct packed {
    logic [7:0]         bin;
    logic               pair;
    logic               re_neg;
    logic               im_neg;
    logic [15:0]        ax;
    logic [15:0]        ay;
    logic [31:0]        sqa;
    logic [31:0]        sqb;
    logic signed [26:0] x;
    logic signed [26:0] y;
    logic signed [18:0] z;
    logic [31:0]        rem;
    logic [31:0]        root;
    logic [15:0]        mag;
    logic signed [16:0] phase;
  } pipe_t;

  function automatic pipe_t load_item(item_t it);
    pipe_t p;
    p        = '0;
    p.bin    = it.bin;
    p.pair   = it.pair;
    p.re_neg = it.re_neg;
    p.im_neg = it.im_neg;
    p.ax     = it.ax;
    p.ay     = it.ay;
    p.sqa    = 32'(it.ax) * 32'(it.ax);
    p.sqb    = 32'(it.ay) * 32'(it.ay);
    p.x      = signed'({3'b000, it.ax, 8'h00});
    p.y      = signed'({3'b000, it.ay, 8'h00});
    return p;
  endfunction

  function automatic pipe_t cordic_step(pipe_t p, int unsigned i);
    pipe_t              n;
    logic signed [18:0] t;
    n = p;
    t = signed'({2'b00, CORDIC_ATAN[i]});
    if (!p.y[26] && (p.y != '0)) begin
      n.x = p.x + (p.y >>> i);
      n.y = p.y - (p.x >>> i);
      n.z = p.z + t;
    end else if (p.y[26]) begin
      n.x = p.x - (p.y >>> i);
      n.y = p.y + (p.x >>> i);
      n.z = p.z - t;
    end
    return n;
  endfunction

  function automatic pipe_t sum_squares(pipe_t p);
    pipe_t n;
    n      = p;
    n.rem  = p.sqa + p.sqb;
    n.root = '0;
    return n;
  endfunction

  function automatic pipe_t sqrt_step(pipe_t p, int unsigned j);
    pipe_t       n;
    logic [31:0] b;
    logic [32:0] t;
    n = p;
    b = 32'd1 << (30 - 2 * j);
    t = {1'b0, p.root} + {1'b0, b};
    if ({1'b0, p.rem} >= t) begin
      n.rem  = p.rem - t[31:0];
      n.root = (p.root >> 1) + b;
    end else begin
      n.root = p.root >> 1;
    end
    return n;
  endfunction

  // The remainder is s - root^2, so s > root^2 + root reduces to rem > root.
  function automatic pipe_t sqrt_round(pipe_t p);
    pipe_t n;
    n = p;
    if (p.rem > p.root) begin
      n.mag = 16'(p.root + 32'd1);
    end else begin
      n.mag = 16'(p.root);
    end
    return n;
  endfunction

  function automatic pipe_t finish(pipe_t p);
    pipe_t              n;
    logic [17:0]        zc;
    logic [14:0]        ang;
    logic signed [16:0] ang_s;
    n = p;
    if (p.z[18]) begin
      zc = '0;
    end else if (p.z > signed'({1'b0, Z_CLAMP})) begin
      zc = Z_CLAMP;
    end else begin
      zc = 18'(p.z);
    end
    ang = 15'((zc + 18'd4) >> 3);
    // Vectors on an axis get exact angles.
    if (p.ay == '0) begin
      ang = '0;
    end else if (p.ax == '0) begin
      ang = HALF_PI;
    end
    ang_s = signed'({2'b00, ang});
    unique case ({p.re_neg, p.im_neg})
      2'b00:   n.phase = ang_s;
      2'b01:   n.phase = -ang_s;
      2'b10:   n.phase = PHASE_PI - ang_s;
      default: n.phase = ang_s - PHASE_PI;
    endcase
    return n;
  endfunction

  pipe_t          st_q [NST];
  pipe_t          st_d [NST];
  logic [NST-1:0] st_v_q;
  logic           adv;
  pipe_t          tail;

  assign st_d[0] = load_item(item_i);

  for (genvar k = 1; k < NST; k++) begin : g_stage
    pipe_t c_w;
    if (k <= CORDIC_STAGES) begin : g_rot
      assign c_w = cordic_step(st_q[k-1], k - 1);
    end else begin : g_norot
      assign c_w = st_q[k-1];
    end
    if (k == 1) begin : g_sum
      assign st_d[k] = sum_squares(c_w);
    end else if (k < SQRT_FIRST + SQRT_STEPS) begin : g_sqrt
      assign st_d[k] = sqrt_step(c_w, k - SQRT_FIRST);
    end else if (k == SQRT_FIRST + SQRT_STEPS) begin : g_round
      assign st_d[k] = sqrt_round(c_w);
    end else begin : g_finish
      assign st_d[k] = finish(c_w);
    end
  end

  assign tail      = st_q[NST-1];
  assign adv       = !st_v_q[NST-1] ||
                     (rq_free_i >= (tail.pair ? RQ_CW'(2) : RQ_CW'(1)));
  assign item_rd_o = adv && item_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q <= '0;
    end else if (adv) begin
      st_v_q <= {st_v_q[NST-2:0], item_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  always_comb begin
    wr_o.v0 = adv && st_v_q[NST-1];
    wr_o.v1 = adv && st_v_q[NST-1] && tail.pair;
    if (tail.pair) begin
      wr_o.r0.bin   = 9'd0;
      wr_o.r0.mag   = tail.ax;
      wr_o.r0.phase = tail.re_neg ? PHASE_PI : 17'sd0;
      wr_o.r0.last  = 1'b0;
    end else begin
      wr_o.r0.bin   = {1'b0, tail.bin};
      wr_o.r0.mag   = tail.mag;
      wr_o.r0.phase = tail.phase;
      wr_o.r0.last  = 1'b1;
    end
    wr_o.r1.bin   = NYQ_BIN;
    wr_o.r1.mag   = tail.ay;
    wr_o.r1.phase = tail.im_neg ? PHASE_PI : 17'sd0;
    wr_o.r1.last  = 1'b1;
  end

  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_o.v0 && !tail.pair) |-> (wr_o.r0.mag <= MAG_MAX))
    else $error("ordinary bin magnitude out of range");

endmodule

// ----- hdl/psp_result_queue.sv -----
// ----------------------------------------------------------------------------
// psp_result_queue: result queue of the spectrum-to-polar converter
// Takes one or two results per cycle from the pipeline and hands them out
// one at a time, oldest first, reporting its free space to the pipeline.
// ----------------------------------------------------------------------------
module psp_result_queue import psp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  res_wr_t          wr_i,
  output logic [RQ_CW-1:0] free_o,
  output logic             empty,
  input  logic             pop,
  output result_t          head_o
);

  result_t          mem_q [RQ_DEPTH];
  logic [RQ_AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [RQ_CW-1:0] count_q, count_d;
  logic             rd;

  assign empty  = (count_q == '0);
  assign rd     = pop && !empty;
  assign head_o = mem_q[rptr_q];
  assign free_o = RQ_CW'(RQ_DEPTH) - count_q;

  always_comb begin
    wptr_d  = wptr_q + RQ_AW'(wr_i.v0) + RQ_AW'(wr_i.v1);
    rptr_d  = rptr_q + RQ_AW'(rd);
    count_d = count_q + RQ_CW'(wr_i.v0) + RQ_CW'(wr_i.v1) - RQ_CW'(rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.v0) begin
      mem_q[wptr_q] <= wr_i.r0;
    end
    if (wr_i.v1) begin
      mem_q[wptr_q + RQ_AW'(1)] <= wr_i.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.v0 |-> ((32'(count_q) + 32'(wr_i.v0) + 32'(wr_i.v1)) <= RQ_DEPTH))
    else $error("result queue written beyond its depth");

  a_lane_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.v1 |-> wr_i.v0)
    else $error("second result lane written without the first");

endmodule
